@@ sv/fastcgi_response_deframer_macros.svh @@
// Assertion macros for the FastCGI response deframer.
`ifndef FASTCGI_RESPONSE_DEFRAMER_MACROS_SVH
`define FASTCGI_RESPONSE_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

`define FRD_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("deframer check failed");

`define FRD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("deframer check failed");

`else

`define FRD_ASSERT_IMP(label, clk, rst_n, a, b)

`define FRD_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

@@ sv/fcgi_rd_pkg.sv @@
package fcgi_rd_pkg;

    localparam logic [2:0] HDR_LAST_INDEX   = 3'd7;
    localparam logic [2:0] HDR_TYPE_INDEX   = 3'd1;
    localparam logic [2:0] HDR_LEN_HI_INDEX = 3'd4;
    localparam logic [2:0] HDR_LEN_LO_INDEX = 3'd5;
    localparam logic [2:0] HDR_PAD_INDEX    = 3'd6;
    localparam logic [2:0] END_PSTAT_INDEX  = 3'd4;

    localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [7:0] TYPE_STDOUT      = 8'd6;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CONTENT = 3'd1,
        PH_PADDING = 3'd2,
        PH_ENDBODY = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_response;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  content_byte;
        logic        record_last;
        logic [31:0] app_code;
        logic [7:0]  proto_code;
    } out_word_t;

endpackage

@@ sv/fastcgi_response_deframer.sv @@
// FastCGI response deframer.
// Byte channel: byte_valid / byte_stall / byte_word carry one stream byte per
// word, with new_response set on the first byte of a new response to clear
// the parser. Result channel: result_valid / result_stall / result_word carry
// one result word: a STDOUT content byte (record_last on the final byte of a
// record), the END_REQUEST app and protocol status, or a protocol error.
// Padding bytes and most header and end-body bytes produce no result.
// An accepted byte is held in the input register and its result, if any, in
// the result register.
// Throughput: one byte per cycle unless the receiver stalls; the parser state
// update is a single pass of short logic between input and result registers.
// Reset clears the input and result valids and puts the parser in header
// phase with all counters zero. While the receiver stalls, the result word
// holds; one more byte is taken into the input register, after which
// byte_stall rises until the result is taken. After an error the parser
// stays silent until a byte with new_response set.
`include "fastcgi_response_deframer_macros.svh"

module fastcgi_response_deframer
    import fcgi_rd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_word_t  byte_word,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result_word
);

    logic      s1_valid_reg, s1_valid_next;
    in_word_t  s1_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  record_type_reg, record_type_next;
    logic [15:0] content_left_reg, content_left_next;
    logic [7:0]  padding_left_reg, padding_left_next;
    logic [31:0] status_shift_reg, status_shift_next;

    logic      out_free;
    logic      fire;
    logic      accept;
    logic      res_valid;
    out_word_t res_word;

    phase_t      ph;
    logic [2:0]  bi;
    logic [7:0]  rt;
    logic [15:0] cl;
    logic [7:0]  pl;
    logic [31:0] ss;
    logic [7:0]  b;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;
    assign accept     = byte_valid && !byte_stall;

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    always_comb
    begin
        b = s1_word_reg.in_byte;
        if (s1_word_reg.new_response)
        begin
            ph = PH_HEADER;
            bi = '0;
            rt = '0;
            cl = '0;
            pl = '0;
            ss = '0;
        end
        else
        begin
            ph = phase_reg;
            bi = byte_index_reg;
            rt = record_type_reg;
            cl = content_left_reg;
            pl = padding_left_reg;
            ss = status_shift_reg;
        end

        res_valid = 1'b0;
        res_word  = '0;

        unique case (ph)
            PH_HEADER:
            begin
                if (bi == HDR_TYPE_INDEX)   rt = b;
                if (bi == HDR_LEN_HI_INDEX) cl = {b, cl[7:0]};
                if (bi == HDR_LEN_LO_INDEX) cl = {cl[15:8], b};
                if (bi == HDR_PAD_INDEX)    pl = b;
                if (bi != HDR_LAST_INDEX)
                begin
                    bi = bi + 3'd1;
                end
                else
                begin
                    bi = '0;
                    priority if (rt == TYPE_STDOUT)
                    begin
                        if (cl != 16'd0)
                            ph = PH_CONTENT;
                        else if (pl != 8'd0)
                            ph = PH_PADDING;
                    end
                    else if (rt == TYPE_END_REQUEST)
                    begin
                        ss = '0;
                        rt = '0;
                        ph = PH_ENDBODY;
                    end
                    else
                    begin
                        ph                = PH_ERROR;
                        res_valid         = 1'b1;
                        res_word.out_kind = KIND_ERROR;
                    end
                end
            end
            PH_CONTENT:
            begin
                cl                    = cl - 16'd1;
                res_valid             = 1'b1;
                res_word.out_kind     = KIND_CONTENT;
                res_word.content_byte = b;
                if (cl == 16'd0)
                begin
                    res_word.record_last = 1'b1;
                    ph = (pl != 8'd0) ? PH_PADDING : PH_HEADER;
                end
            end
            PH_PADDING:
            begin
                pl = pl - 8'd1;
                if (pl == 8'd0)
                    ph = PH_HEADER;
            end
            PH_ENDBODY:
            begin
                if (bi < END_PSTAT_INDEX)
                    ss = {ss[23:0], b};
                else if (bi == END_PSTAT_INDEX)
                    rt = b;
                if (bi != HDR_LAST_INDEX)
                begin
                    bi = bi + 3'd1;
                end
                else
                begin
                    bi                  = '0;
                    ph                  = PH_DONE;
                    res_valid           = 1'b1;
                    res_word.out_kind   = KIND_END;
                    res_word.app_code   = ss;
                    res_word.proto_code = rt;
                end
            end
            PH_DONE:
            begin
                ph                = PH_ERROR;
                res_valid         = 1'b1;
                res_word.out_kind = KIND_ERROR;
            end
            default:
            begin
                ph = PH_ERROR;
            end
        endcase

        phase_next        = ph;
        byte_index_next   = bi;
        record_type_next  = rt;
        content_left_next = cl;
        padding_left_next = pl;
        status_shift_next = ss;

        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_HEADER;
            byte_index_reg   <= '0;
            record_type_reg  <= '0;
            content_left_reg <= '0;
            padding_left_reg <= '0;
            status_shift_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (fire)
            begin
                phase_reg        <= phase_next;
                byte_index_reg   <= byte_index_next;
                record_type_reg  <= record_type_next;
                content_left_reg <= content_left_next;
                padding_left_reg <= padding_left_next;
                status_shift_reg <= status_shift_next;
            end
            if (fire && res_valid)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_word_reg <= byte_word;
        if (fire && res_valid)
            out_word_reg <= res_word;
    end

    `FRD_ASSERT_NEXT(a_error_holds, clk, rst_n,
        fire && res_valid && (res_word.out_kind == KIND_ERROR), phase_reg == PH_ERROR)
    `FRD_ASSERT_IMP(a_last_is_content, clk, rst_n,
        out_valid_reg && out_word_reg.record_last, out_word_reg.out_kind == KIND_CONTENT)
    `FRD_ASSERT_IMP(a_content_nonzero, clk, rst_n,
        phase_reg == PH_CONTENT, content_left_reg != 16'd0)
    `FRD_ASSERT_IMP(a_stall_needs_pending, clk, rst_n,
        byte_stall, s1_valid_reg && out_valid_reg && result_stall)

endmodule
